// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/phkv_pkg.sv
// Package with the types, codes and helper functions of the paged hash store.
`timescale 1ns / 1ps
package phkv_pkg;

    localparam int TS_W = 11;
    localparam int KB_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] FN_GET = 2'd0;
    localparam logic [1:0] FN_PUT = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;
    localparam logic [1:0] FN_NEXT = 2'd3;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_END = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES = 2'd1;

    localparam logic [TS_W-1:0] TS_RESET = 11'd1024;
    localparam logic [KB_W-1:0] KB_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;
        logic [63:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] key_out;
        logic [63:0] value_out;
    } t_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_IREAD,
        S_ICHECK
    } t_state;

    function automatic logic [KB_W-1:0] eff_kbytes(input logic [KB_W-1:0] kb);
        logic [KB_W-1:0] r;
        r = kb;
        if (kb == '0) begin
            r = 4'd1;
        end else if (kb > 4'd8) begin
            r = 4'd8;
        end
        return r;
    endfunction

    function automatic logic [63:0] key_mask(input logic [KB_W-1:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(n)) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/phkv_hash.sv
// Byte-serial djb2 hash followed by a bit-serial remainder by the table size.
`timescale 1ns / 1ps
module phkv_hash (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [63:0]              i_key,
    input  logic [phkv_pkg::KB_W-1:0] i_nbytes,
    input  logic [phkv_pkg::TS_W-1:0] i_mod,
    output logic                     o_done,
    output logic [phkv_pkg::TS_W-1:0] o_rem
);
    logic                      r_run;
    logic                      r_div;
    logic                      r_done;
    logic [6:0]                r_cnt;
    logic [63:0]               r_h;
    logic [63:0]               r_k;
    logic [phkv_pkg::TS_W-1:0] r_rem;
    logic [phkv_pkg::TS_W-1:0] r_mod;
    logic [phkv_pkg::TS_W:0]   n_trial;
    logic [phkv_pkg::TS_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_h[63]};
        if (n_trial >= {1'b0, r_mod}) begin
            n_rem = phkv_pkg::TS_W'(n_trial - {1'b0, r_mod});
        end else begin
            n_rem = phkv_pkg::TS_W'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_div <= 1'b0;
                r_h   <= phkv_pkg::HASH_SEED;
                r_k   <= i_key;
                r_cnt <= 7'(i_nbytes) - 7'd1;
                r_mod <= i_mod;
            end else if (r_run && !r_div) begin
                r_h <= (r_h << 5) + r_h + {56'd0, r_k[7:0]};
                r_k <= r_k >> 8;
                if (r_cnt == '0) begin
                    r_div <= 1'b1;
                    r_cnt <= 7'd63;
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end else if (r_run) begin
                r_rem <= n_rem;
                r_h   <= r_h << 1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_div  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: rtl/core/phkv_mem.sv
// Entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
module phkv_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 129
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/paged_hash_key_value_store_core.sv
// Top level of the paged hash key-value store.
`timescale 1ns / 1ps
// Usage:
// A command word (func, key, value) is taken at a rising edge with start high
// and busy low. Every command yields exactly one result word on o_res, marked
// by o_res_valid for one cycle; the receiver cannot stall it. Configuration
// words (table_size at index 0, key_bytes at index 1) are written through
// i_cfg_valid/o_cfg_ready and must only be sent while busy is low.
// Sequencing: iterator restart is answered from idle without leaving it. Get and
// put hash the key bytes serially, form the remainder bit-serially, take the
// slot, then visit pages, each visit a memory read followed by the check and,
// for a put, the write back. Iterator next reads and checks slot after slot
// until it finds a valid entry or the table ends. Every visit goes through the
// single entry memory port pair; one command is in flight at a time.
// After reset the block is busy while it clears every entry, one per cycle;
// configuration writes are taken during that pass.
module paged_hash_key_value_store_core #(
    parameter int SLOTS       = 1024,
    parameter int MAX_PAGES   = 8,
    parameter int VALUE_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  phkv_pkg::t_cmd                i_cmd,
    output logic                          busy,
    output logic                          o_res_valid,
    output phkv_pkg::t_res                o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [phkv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [phkv_pkg::TS_W-1:0]      i_cfg_data
);
    localparam int ENTRIES = SLOTS * MAX_PAGES;
    localparam int AW      = $clog2(ENTRIES);
    localparam int SW      = $clog2(SLOTS);
    localparam int PW      = $clog2(MAX_PAGES + 1);
    localparam int DW      = 1 + 64 + VALUE_WIDTH;

    phkv_pkg::t_state r_state, n_state;

    logic [phkv_pkg::TS_W-1:0] r_ts;
    logic [phkv_pkg::KB_W-1:0] r_kb;
    logic [PW-1:0]             r_pages, n_pages;
    logic [PW-1:0]             r_ipage, n_ipage;
    logic [SW-1:0]             r_islot, n_islot;
    logic [PW-1:0]             r_page, n_page;
    logic [SW-1:0]             r_slot, n_slot;
    logic [AW-1:0]             r_clr;
    logic [1:0]                r_func;
    logic [63:0]               r_key;
    logic [VALUE_WIDTH-1:0]    r_val;
    logic                      r_ovalid, n_ovalid;
    phkv_pkg::t_res            r_res, n_res;

    logic [phkv_pkg::TS_W-1:0] ts_eff;
    logic [phkv_pkg::KB_W-1:0] kb_eff;
    logic [63:0]               km;
    logic                      accept;
    logic                      hash_done;
    logic [phkv_pkg::TS_W-1:0] hash_rem;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [DW-1:0]             wdata;
    logic [AW-1:0]             raddr;
    logic [DW-1:0]             rdata;
    logic                      rd_valid;
    logic [63:0]               rd_key;
    logic [VALUE_WIDTH-1:0]    rd_val;
    logic                      rd_match;
    logic [SW:0]               islot_inc;

    function automatic logic [AW-1:0] entry_addr(input logic [PW-1:0] pg,
                                                 input logic [SW-1:0] sl);
        return AW'(32'(pg) * SLOTS + 32'(sl));
    endfunction

    always_comb begin
        ts_eff = r_ts;
        if (r_ts == '0) begin
            ts_eff = 11'd1;
        end else if (32'(r_ts) > SLOTS) begin
            ts_eff = phkv_pkg::TS_W'(SLOTS);
        end
    end

    assign kb_eff = phkv_pkg::eff_kbytes(r_kb);
    assign km     = phkv_pkg::key_mask(kb_eff);
    assign accept = start && (r_state == phkv_pkg::S_IDLE);

    assign rd_valid  = rdata[DW-1];
    assign rd_key    = rdata[DW-2 -: 64];
    assign rd_val    = rdata[VALUE_WIDTH-1:0];
    assign rd_match  = ((rd_key & km) == r_key);
    assign islot_inc = {1'b0, r_islot} + 1'b1;

    phkv_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && (i_cmd.func == phkv_pkg::FN_GET ||
                              i_cmd.func == phkv_pkg::FN_PUT)),
        .i_key    (i_cmd.key & km),
        .i_nbytes (kb_eff),
        .i_mod    (ts_eff),
        .o_done   (hash_done),
        .o_rem    (hash_rem)
    );

    phkv_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            phkv_pkg::S_CLEAR: begin
                if (32'(r_clr) == ENTRIES - 1) begin
                    n_state = phkv_pkg::S_IDLE;
                end
            end
            phkv_pkg::S_IDLE: begin
                if (start) begin
                    case (i_cmd.func)
                        phkv_pkg::FN_GET, phkv_pkg::FN_PUT: n_state = phkv_pkg::S_HASH;
                        phkv_pkg::FN_NEXT: begin
                            if (r_ipage < r_pages && 32'(r_islot) < 32'(ts_eff)) begin
                                n_state = phkv_pkg::S_IREAD;
                            end
                        end
                        default: n_state = phkv_pkg::S_IDLE;
                    endcase
                end
            end
            phkv_pkg::S_HASH: begin
                if (hash_done) begin
                    n_state = (r_pages == '0) ? phkv_pkg::S_IDLE : phkv_pkg::S_READ;
                end
            end
            phkv_pkg::S_READ: n_state = phkv_pkg::S_CHECK;
            phkv_pkg::S_CHECK: begin
                if (rd_valid && !rd_match && (r_page + 1'b1) < r_pages) begin
                    n_state = phkv_pkg::S_READ;
                end else begin
                    n_state = phkv_pkg::S_IDLE;
                end
            end
            phkv_pkg::S_IREAD: n_state = phkv_pkg::S_ICHECK;
            phkv_pkg::S_ICHECK: begin
                if (rd_valid) begin
                    n_state = phkv_pkg::S_IDLE;
                end else if (32'(islot_inc) < 32'(ts_eff)) begin
                    n_state = phkv_pkg::S_IREAD;
                end else if ((r_ipage + 1'b1) < r_pages) begin
                    n_state = phkv_pkg::S_IREAD;
                end else begin
                    n_state = phkv_pkg::S_IDLE;
                end
            end
            default: n_state = phkv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pages  = r_pages;
        n_ipage  = r_ipage;
        n_islot  = r_islot;
        n_page   = r_page;
        n_slot   = r_slot;
        n_ovalid = 1'b0;
        n_res    = '0;
        we       = 1'b0;
        waddr    = entry_addr(r_page, r_slot);
        wdata    = {1'b1, r_key, r_val};
        raddr    = entry_addr(r_page, r_slot);
        case (r_state)
            phkv_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            phkv_pkg::S_IDLE: begin
                if (start) begin
                    case (i_cmd.func)
                        phkv_pkg::FN_RESTART: begin
                            n_ipage  = '0;
                            n_islot  = '0;
                            n_ovalid = 1'b1;
                            n_res.status = phkv_pkg::STAT_OK;
                        end
                        phkv_pkg::FN_NEXT: begin
                            if (!(r_ipage < r_pages && 32'(r_islot) < 32'(ts_eff))) begin
                                n_ovalid = 1'b1;
                                n_res.status = phkv_pkg::STAT_END;
                            end
                        end
                        default: n_page = '0;
                    endcase
                end
            end
            phkv_pkg::S_HASH: begin
                if (hash_done) begin
                    n_slot = SW'(hash_rem);
                    n_page = '0;
                    if (r_pages == '0) begin
                        n_ovalid = 1'b1;
                        if (r_func == phkv_pkg::FN_PUT) begin
                            we      = 1'b1;
                            waddr   = entry_addr('0, SW'(hash_rem));
                            n_pages = PW'(1);
                            n_res.status = phkv_pkg::STAT_OK;
                        end else begin
                            n_res.status = phkv_pkg::STAT_NOTFOUND;
                        end
                    end
                end
            end
            phkv_pkg::S_CHECK: begin
                if (r_func == phkv_pkg::FN_GET) begin
                    if (!rd_valid) begin
                        n_ovalid = 1'b1;
                        n_res.status = phkv_pkg::STAT_NOTFOUND;
                    end else if (rd_match) begin
                        n_ovalid = 1'b1;
                        n_res.status = phkv_pkg::STAT_OK;
                        n_res.value_out = 64'(rd_val);
                    end else if ((r_page + 1'b1) < r_pages) begin
                        n_page = r_page + 1'b1;
                    end else begin
                        n_ovalid = 1'b1;
                        n_res.status = phkv_pkg::STAT_NOTFOUND;
                    end
                end else begin
                    if (!rd_valid || rd_match) begin
                        we       = 1'b1;
                        n_ovalid = 1'b1;
                        n_res.status = phkv_pkg::STAT_OK;
                    end else if ((r_page + 1'b1) < r_pages) begin
                        n_page = r_page + 1'b1;
                    end else if (32'(r_pages) < MAX_PAGES) begin
                        we       = 1'b1;
                        waddr    = entry_addr(r_pages, r_slot);
                        n_pages  = r_pages + 1'b1;
                        n_ovalid = 1'b1;
                        n_res.status = phkv_pkg::STAT_OK;
                    end else begin
                        n_ovalid = 1'b1;
                        n_res.status = phkv_pkg::STAT_FULL;
                    end
                end
            end
            phkv_pkg::S_IREAD: begin
                raddr = entry_addr(r_ipage, r_islot);
            end
            phkv_pkg::S_ICHECK: begin
                if (32'(islot_inc) < 32'(ts_eff)) begin
                    n_islot = SW'(islot_inc);
                end else begin
                    n_islot = '0;
                    n_ipage = r_ipage + 1'b1;
                end
                if (rd_valid) begin
                    n_ovalid = 1'b1;
                    n_res.status = phkv_pkg::STAT_OK;
                    n_res.key_out = rd_key;
                    n_res.value_out = 64'(rd_val);
                end else if (32'(islot_inc) >= 32'(ts_eff) &&
                             (r_ipage + 1'b1) >= r_pages) begin
                    n_ovalid = 1'b1;
                    n_res.status = phkv_pkg::STAT_END;
                end
            end
            default: n_ovalid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= phkv_pkg::S_CLEAR;
            r_clr    <= '0;
            r_ts     <= phkv_pkg::TS_RESET;
            r_kb     <= phkv_pkg::KB_RESET;
            r_pages  <= '0;
            r_ipage  <= '0;
            r_islot  <= '0;
            r_page   <= '0;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= r_clr + 1'b1;
            r_pages  <= n_pages;
            r_ipage  <= n_ipage;
            r_islot  <= n_islot;
            r_page   <= n_page;
            r_slot   <= n_slot;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                if (i_cfg_index == phkv_pkg::REG_TABLE_SIZE) begin
                    r_ts <= i_cfg_data;
                end else if (i_cfg_index == phkv_pkg::REG_KEY_BYTES) begin
                    r_kb <= i_cfg_data[phkv_pkg::KB_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_func <= i_cmd.func;
            r_key  <= i_cmd.key & km;
            r_val  <= i_cmd.value[VALUE_WIDTH-1:0];
        end
    end

    assign busy        = (r_state != phkv_pkg::S_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;
endmodule

// File: rtl/core/phkv_checker.sv
// Port-level checker for the paged hash store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phkv_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_res_valid,
    input phkv_pkg::t_res                 o_res
);
    `AST_NEXT(a_accept_progress, start && !busy, busy || o_res_valid, "Accepted word made no progress")
    `AST_SAME(a_result_idle, o_res_valid, !busy, "Result word shown while busy")
    `AST_SAME(a_full_zero, o_res_valid && o_res.status == phkv_pkg::STAT_FULL, o_res.key_out == '0 && o_res.value_out == '0, "Full result carries data")
    `AST_SAME(a_end_zero, o_res_valid && o_res.status == phkv_pkg::STAT_END, o_res.key_out == '0 && o_res.value_out == '0, "End result carries data")
endmodule

bind paged_hash_key_value_store_core phkv_checker u_phkv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// File: tb/tb_paged_hash_key_value_store_core.sv
// Self-checking testbench of the paged hash key-value store core.
`timescale 1ns / 1ps

class phkv_scoreboard;
    localparam int NSLOT = 1024;
    localparam int NPAGE = 8;

    bit          slot_used [NSLOT*NPAGE];
    logic [63:0] slot_key  [NSLOT*NPAGE];
    logic [63:0] slot_data [NSLOT*NPAGE];
    int unsigned pages, it_page, it_slot;
    logic [10:0] tsize;
    logic [3:0]  kbytes;
    phkv_pkg::t_res expected_q[$];
    int errors;

    function new();
        foreach (slot_used[i]) slot_used[i] = 0;
        pages = 0;
        it_page = 0;
        it_slot = 0;
        tsize = phkv_pkg::TS_RESET;
        kbytes = phkv_pkg::KB_RESET;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
        if (idx == phkv_pkg::REG_TABLE_SIZE) tsize = data;
        else if (idx == phkv_pkg::REG_KEY_BYTES) kbytes = data[3:0];
    endfunction

    function int unsigned slots_used();
        if (tsize == 0) return 1;
        if (tsize > NSLOT) return NSLOT;
        return tsize;
    endfunction

    function int unsigned bytes_used();
        if (kbytes == 0) return 1;
        if (kbytes > 8) return 8;
        return kbytes;
    endfunction

    function logic [63:0] kmask();
        if (bytes_used() >= 8) return '1;
        return (64'd1 << (8 * bytes_used())) - 64'd1;
    endfunction

    function int unsigned hash_slot(logic [63:0] k);
        logic [63:0] h;
        h = 64'd5381;
        for (int i = 0; i < bytes_used(); i++) h = (h << 5) + h + k[8*i +: 8];
        return int'(h % slots_used());
    endfunction

    function void note(phkv_pkg::t_cmd c);
        phkv_pkg::t_res r;
        logic [63:0] km, k;
        int unsigned s, idx, ts;
        bit done, found;
        km = kmask();
        k = c.key & km;
        ts = slots_used();
        r = '0;
        r.status = phkv_pkg::STAT_OK;
        case (c.func)
            phkv_pkg::FN_GET: begin
                s = hash_slot(k);
                r.status = phkv_pkg::STAT_NOTFOUND;
                for (int p = 0; p < pages; p++) begin
                    idx = p * NSLOT + s;
                    if (!slot_used[idx]) break;
                    if ((slot_key[idx] & km) == k) begin
                        r.status = phkv_pkg::STAT_OK;
                        r.value_out = slot_data[idx];
                        break;
                    end
                end
            end
            phkv_pkg::FN_PUT: begin
                s = hash_slot(k);
                done = 0;
                for (int p = 0; p < pages; p++) begin
                    idx = p * NSLOT + s;
                    if (!slot_used[idx] || (slot_key[idx] & km) == k) begin
                        slot_used[idx] = 1;
                        slot_key[idx] = k;
                        slot_data[idx] = c.value;
                        done = 1;
                        break;
                    end
                end
                if (!done) begin
                    if (pages < NPAGE) begin
                        idx = pages * NSLOT + s;
                        slot_used[idx] = 1;
                        slot_key[idx] = k;
                        slot_data[idx] = c.value;
                        pages++;
                    end else begin
                        r.status = phkv_pkg::STAT_FULL;
                    end
                end
            end
            phkv_pkg::FN_RESTART: begin
                it_page = 0;
                it_slot = 0;
            end
            default: begin
                r.status = phkv_pkg::STAT_END;
                if (it_page < pages && it_slot < ts) begin
                    found = 1;
                    forever begin
                        if (slot_used[it_page * NSLOT + it_slot]) break;
                        it_slot++;
                        if (it_slot >= ts) begin
                            it_slot = 0;
                            it_page++;
                            if (it_page >= pages) begin
                                found = 0;
                                break;
                            end
                        end
                    end
                    if (found) begin
                        idx = it_page * NSLOT + it_slot;
                        r.status = phkv_pkg::STAT_OK;
                        r.key_out = slot_key[idx];
                        r.value_out = slot_data[idx];
                        it_slot++;
                        if (it_slot >= ts) begin
                            it_slot = 0;
                            it_page++;
                        end
                    end
                end
            end
        endcase
        expected_q.push_back(r);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task check(phkv_pkg::t_res got);
        phkv_pkg::t_res w;
        if (expected_q.size() == 0) begin
            report("result word with nothing expected");
            return;
        end
        w = expected_q.pop_front();
        if (got.status !== w.status)
            report($sformatf("status %0d, expected %0d", got.status, w.status));
        if (got.key_out !== w.key_out)
            report($sformatf("key_out %h, expected %h", got.key_out, w.key_out));
        if (got.value_out !== w.value_out)
            report($sformatf("value_out %h, expected %h", got.value_out, w.value_out));
    endtask
endclass

module tb_paged_hash_key_value_store_core;
    localparam int STALL_LIMIT = 60000;

    logic i_clk = 0;
    logic i_rst_n;
    logic start;
    phkv_pkg::t_cmd i_cmd;
    logic busy;
    logic o_res_valid;
    phkv_pkg::t_res o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [phkv_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [phkv_pkg::TS_W-1:0] i_cfg_data;

    phkv_scoreboard sb = new();
    bit no_idle;
    int stall_cycles;
    logic [63:0] key_pool [10];

    paged_hash_key_value_store_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd), .busy(busy),
        .o_res_valid(o_res_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) sb.check(o_res);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles > STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task send(logic [1:0] fn, logic [63:0] k, logic [63:0] v);
        phkv_pkg::t_cmd c;
        c.func = fn;
        c.key = k;
        c.value = v;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note(c);
    endtask

    task pause_maybe();
        if (!no_idle && $urandom_range(99) < 20) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [10:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task random_phase(int n, bit big_table);
        int r;
        logic [1:0] fn;
        logic [63:0] k;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 38) fn = phkv_pkg::FN_PUT;
            else if (r < 75) fn = phkv_pkg::FN_GET;
            else if (r < 85) fn = phkv_pkg::FN_RESTART;
            else fn = (big_table && $urandom_range(9) != 0) ? phkv_pkg::FN_GET
                                                              : phkv_pkg::FN_NEXT;
            k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(9)]
                                          : {$urandom, $urandom};
            send(fn, k, {$urandom, $urandom});
            pause_maybe();
            if (i == n / 2 && $urandom_range(1)) drain();
        end
        drain();
    endtask

    initial begin
        logic [10:0] ts_list [10] = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd3,
                                      11'd7, 11'd2, 11'd16, 11'd1000, 11'd5};
        logic [10:0] kb_list [10] = '{11'd8, 11'd8, 11'd0, 11'd15, 11'd1,
                                      11'd2, 11'd9, 11'd3, 11'd4, 11'd8};
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        stall_cycles <= 0;
        no_idle = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        send(phkv_pkg::FN_GET, 64'd0, 64'd0);
        send(phkv_pkg::FN_NEXT, '1, '1);
        send(phkv_pkg::FN_RESTART, 64'd5, 64'd6);
        send(phkv_pkg::FN_PUT, 64'd0, '1);
        send(phkv_pkg::FN_PUT, '1, 64'd0);
        send(phkv_pkg::FN_GET, 64'd0, 64'd0);
        send(phkv_pkg::FN_GET, '1, 64'd0);
        send(phkv_pkg::FN_PUT, 64'd0, 64'h0123_4567_89ab_cdef);
        send(phkv_pkg::FN_GET, 64'd0, 64'd0);
        send(phkv_pkg::FN_RESTART, 64'd0, 64'd0);
        repeat (3) send(phkv_pkg::FN_NEXT, 64'd0, 64'd0);
        drain();
        write_reg(phkv_pkg::REG_TABLE_SIZE, 11'd1);
        write_reg(2'd2, 11'd5);
        write_reg(2'd3, 11'd7);
        for (int i = 0; i < 9; i++) send(phkv_pkg::FN_PUT, 64'd100 + i, {$urandom, $urandom});
        send(phkv_pkg::FN_GET, 64'd108, 64'd0);
        send(phkv_pkg::FN_GET, 64'd100, 64'd0);
        send(phkv_pkg::FN_RESTART, 64'd0, 64'd0);
        repeat (5) send(phkv_pkg::FN_NEXT, 64'd0, 64'd0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(phkv_pkg::REG_TABLE_SIZE, ts_list[ph]);
            write_reg(phkv_pkg::REG_KEY_BYTES, kb_list[ph]);
            no_idle = (ph == 4);
            random_phase(40, ts_list[ph] > 64);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
